// ===== rtl/core/assert_macros.svh =====
// Assertion helpers for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Assert that prop holds at every clock edge outside reset.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Assert that ante at one edge implies cons at the next edge.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/pcvc_pkg.sv =====
package pcvc_pkg;

  typedef struct packed {
    logic               present;
    logic        [12:0] low_cell_mv;
    logic        [12:0] high_cell_mv;
    logic        [12:0] avg_cell_mv;
    logic        [15:0] module_mv;
    logic signed [11:0] low_temp_dc;
    logic signed [11:0] high_temp_dc;
    logic               last_of_scan;
    logic               fault_line;
  } in_item_t;

  typedef struct packed {
    logic        [12:0] smooth_low_mv;
    logic        [12:0] smooth_high_mv;
    logic        [12:0] avg_smooth_mv;
    logic        [19:0] pack_mv;
    logic        [19:0] pack_max_mv;
    logic        [19:0] pack_min_mv;
    logic signed [11:0] temp_min_dc;
    logic signed [11:0] temp_max_dc;
    logic               faulted;
  } out_item_t;

  // Closed scan summary passed from front to back.
  typedef struct packed {
    logic               any;
    logic        [12:0] low_mv;
    logic        [12:0] high_mv;
    logic        [16:0] sum_avg;
    logic        [19:0] sum_module;
    logic        [4:0]  count;
    logic signed [11:0] temp_min;
    logic signed [11:0] temp_max;
    logic               fault;
  } scan_t;

  localparam int unsigned CFG_STEP_MV  = 0;
  localparam int unsigned CFG_STRINGS  = 1;

  localparam logic [12:0] CELL_START_MV  = 13'd5000;
  localparam logic [16:0] MEAN_LIMIT_MV  = 17'd10000;
  localparam logic [19:0] PACK_FLOOR_RST = 20'd1000000;
  localparam logic signed [11:0] TEMP_FLOOR_RST = 12'sd2000;
  localparam logic signed [11:0] TEMP_PEAK_RST  = -12'sd1000;

endpackage

// ===== rtl/core/pcvc_front.sv =====
module pcvc_front #(
  parameter int MAX_MODULES = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  pcvc_pkg::in_item_t in_data,
  output logic              scan_valid,
  input  logic              scan_ready,
  output pcvc_pkg::scan_t   scan_data
);

  logic        [12:0] low_r, low_nxt, high_r, high_nxt;
  logic        [16:0] sav_r, sav_nxt;
  logic        [19:0] smod_r, smod_nxt;
  logic        [4:0]  cnt_r, cnt_nxt;
  logic               any_r, any_nxt;
  logic signed [11:0] tmin_r, tmin_nxt, tmax_r, tmax_nxt;
  logic        [17:0] sav_sum;
  logic        [20:0] smod_sum;
  logic               take, acc;

  // Stall only when a closed scan cannot enter the queue.
  assign in_stall = in_data.last_of_scan && !scan_ready;
  assign take     = in_valid && !in_stall;
  assign acc      = take && in_data.present && (cnt_r < 5'(MAX_MODULES));
  assign sav_sum  = {1'b0, sav_r} + 18'(in_data.avg_cell_mv);
  assign smod_sum = {1'b0, smod_r} + 21'(in_data.module_mv);

  always_comb begin
    low_nxt  = low_r;
    high_nxt = high_r;
    sav_nxt  = sav_r;
    smod_nxt = smod_r;
    cnt_nxt  = cnt_r;
    any_nxt  = any_r;
    tmin_nxt = tmin_r;
    tmax_nxt = tmax_r;
    if (acc) begin
      if (in_data.low_cell_mv < low_r) low_nxt = in_data.low_cell_mv;
      if (in_data.high_cell_mv > high_r) high_nxt = in_data.high_cell_mv;
      sav_nxt  = sav_sum[17] ? '1 : sav_sum[16:0];
      smod_nxt = smod_sum[20] ? '1 : smod_sum[19:0];
      cnt_nxt  = cnt_r + 5'd1;
      any_nxt  = 1'b1;
      if (in_data.low_temp_dc < tmin_r) tmin_nxt = in_data.low_temp_dc;
      if (in_data.high_temp_dc > tmax_r) tmax_nxt = in_data.high_temp_dc;
    end
  end

  assign scan_valid         = take && in_data.last_of_scan;
  assign scan_data.any      = any_nxt;
  assign scan_data.low_mv   = low_nxt;
  assign scan_data.high_mv  = high_nxt;
  assign scan_data.sum_avg  = sav_nxt;
  assign scan_data.sum_module = smod_nxt;
  assign scan_data.count    = cnt_nxt;
  assign scan_data.temp_min = tmin_nxt;
  assign scan_data.temp_max = tmax_nxt;
  assign scan_data.fault    = !in_data.fault_line;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      low_r  <= pcvc_pkg::CELL_START_MV;
      high_r <= '0;
      sav_r  <= '0;
      smod_r <= '0;
      cnt_r  <= '0;
      any_r  <= 1'b0;
      tmin_r <= pcvc_pkg::TEMP_FLOOR_RST;
      tmax_r <= pcvc_pkg::TEMP_PEAK_RST;
    end else begin
      tmin_r <= tmin_nxt;
      tmax_r <= tmax_nxt;
      if (scan_valid) begin
        low_r  <= pcvc_pkg::CELL_START_MV;
        high_r <= '0;
        sav_r  <= '0;
        smod_r <= '0;
        cnt_r  <= '0;
        any_r  <= 1'b0;
      end else begin
        low_r  <= low_nxt;
        high_r <= high_nxt;
        sav_r  <= sav_nxt;
        smod_r <= smod_nxt;
        cnt_r  <= cnt_nxt;
        any_r  <= any_nxt;
      end
    end
  end

endmodule

// ===== rtl/core/pcvc_queue.sv =====
module pcvc_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            wr_valid,
  output logic            wr_ready,
  input  pcvc_pkg::scan_t wr_data,
  output logic            rd_valid,
  input  logic            rd_take,
  output pcvc_pkg::scan_t rd_data
);

  // Two-entry queue.
  pcvc_pkg::scan_t mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;

  assign wr_ready = cnt_r != 2'd2;
  assign rd_valid = cnt_r != 2'd0;
  assign rd_data  = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (wr_valid && wr_ready) mem_r[wp_r] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= '0;
    end else begin
      if (wr_valid && wr_ready) wp_r <= !wp_r;
      if (rd_take && rd_valid) rp_r <= !rp_r;
      cnt_r <= cnt_r + 2'(wr_valid && wr_ready) - 2'(rd_take && rd_valid);
    end
  end

endmodule

// ===== rtl/core/pcvc_back.sv =====
`include "assert_macros.svh"

module pcvc_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [9:0]        step_mv,
  input  logic [4:0]        strings,
  input  logic              scan_valid,
  output logic              scan_take,
  input  pcvc_pkg::scan_t   scan_data,
  output logic              out_valid,
  input  logic              out_stall,
  output pcvc_pkg::out_item_t out_data
);

  typedef enum logic [2:0] {
    S_IDLE, S_SLEW, S_DIV, S_RING, S_PACK, S_OUT
  } state_t;

  state_t state_r;
  pcvc_pkg::scan_t sc_r;
  logic [12:0] raw_lo_r, raw_hi_r, sm_lo_r, sm_hi_r;
  logic [12:0] ring_r [8];
  logic [2:0]  pos_r;
  logic [15:0] total_r;
  logic [12:0] held_r;
  logic [19:0] peak_r, floor_r, pack_r;
  // Shared restoring divider: quotient shifts in from the dividend register.
  logic [19:0] quo_r;
  logic [19:0] rem_r;
  logic [4:0]  dvs_r;
  logic [4:0]  bit_r;
  logic [20:0] rem_sh;
  logic [20:0] rem_diff;
  logic [12:0] lo_base, hi_base;

  function automatic logic [12:0] slew_f(logic [12:0] cur, logic [12:0] tgt,
                                         logic [9:0] step);
    logic [12:0] gap_mv;
    gap_mv = (cur > tgt) ? cur - tgt : tgt - cur;
    if (gap_mv > 13'(step)) return (cur > tgt) ? cur - 13'(step) : cur + 13'(step);
    return tgt;
  endfunction

  assign rem_sh   = {rem_r, quo_r[19]};
  assign rem_diff = rem_sh - 21'(dvs_r);
  assign lo_base  = (sm_lo_r == '0 && sm_hi_r == '0) ? raw_lo_r : sm_lo_r;
  assign hi_base  = (sm_lo_r == '0 && sm_hi_r == '0) ? raw_hi_r : sm_hi_r;
  assign scan_take = (state_r == S_IDLE) && scan_valid;
  assign out_valid = state_r == S_OUT;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      raw_lo_r <= '0;
      raw_hi_r <= '0;
      sm_lo_r  <= '0;
      sm_hi_r  <= '0;
      for (int i = 0; i < 8; i++) ring_r[i] <= '0;
      pos_r    <= '0;
      total_r  <= '0;
      held_r   <= '0;
      peak_r   <= '0;
      floor_r  <= pcvc_pkg::PACK_FLOOR_RST;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (scan_valid) begin
            sc_r    <= scan_data;
            if (scan_data.any) begin
              raw_lo_r <= scan_data.low_mv;
              raw_hi_r <= scan_data.high_mv;
            end
            state_r <= S_SLEW;
          end
        end
        S_SLEW: begin
          sm_lo_r <= slew_f(lo_base, raw_lo_r, step_mv);
          sm_hi_r <= slew_f(hi_base, raw_hi_r, step_mv);
          quo_r   <= {sc_r.sum_avg, 3'b000};
          rem_r   <= '0;
          dvs_r   <= sc_r.count;
          bit_r   <= 5'd17;
          state_r <= (sc_r.count == '0) ? S_RING : S_DIV;
        end
        S_DIV: begin
          if (!rem_diff[20]) begin
            rem_r <= rem_diff[19:0];
            quo_r <= {quo_r[18:0], 1'b1};
          end else begin
            rem_r <= rem_sh[19:0];
            quo_r <= {quo_r[18:0], 1'b0};
          end
          bit_r <= bit_r - 5'd1;
          if (bit_r == 5'd1) state_r <= S_RING;
        end
        S_RING: begin
          // Mean (17-bit quotient) enters the ring when inside the window.
          if (sc_r.count != '0 && quo_r[16:0] != '0 &&
              quo_r[16:0] < pcvc_pkg::MEAN_LIMIT_MV) begin
            total_r       <= total_r - 16'(ring_r[pos_r]) + 16'(quo_r[16:0]);
            held_r        <= 13'((total_r - 16'(ring_r[pos_r]) + 16'(quo_r[16:0])) >> 3);
            ring_r[pos_r] <= quo_r[12:0];
            pos_r         <= pos_r + 3'd1;
          end
          quo_r   <= sc_r.sum_module;
          rem_r   <= '0;
          dvs_r   <= (strings == '0) ? 5'd1 : strings;
          bit_r   <= 5'd20;
          state_r <= S_PACK;
        end
        S_PACK: begin
          if (!rem_diff[20]) begin
            rem_r <= rem_diff[19:0];
            quo_r <= {quo_r[18:0], 1'b1};
          end else begin
            rem_r <= rem_sh[19:0];
            quo_r <= {quo_r[18:0], 1'b0};
          end
          bit_r <= bit_r - 5'd1;
          if (bit_r == 5'd1) begin
            pack_r  <= {quo_r[18:0], !rem_diff[20]};
            if ({quo_r[18:0], !rem_diff[20]} > peak_r) peak_r <= {quo_r[18:0], !rem_diff[20]};
            if ({quo_r[18:0], !rem_diff[20]} < floor_r) floor_r <= {quo_r[18:0], !rem_diff[20]};
            state_r <= S_OUT;
          end
        end
        S_OUT: begin
          if (!out_stall) state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_data.smooth_low_mv  = sm_lo_r;
  assign out_data.smooth_high_mv = sm_hi_r;
  assign out_data.avg_smooth_mv  = held_r;
  assign out_data.pack_mv        = pack_r;
  assign out_data.pack_max_mv    = peak_r;
  assign out_data.pack_min_mv    = floor_r;
  assign out_data.temp_min_dc    = sc_r.temp_min;
  assign out_data.temp_max_dc    = sc_r.temp_max;
  assign out_data.faulted        = sc_r.fault;

  `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_data),
               "result changed under stall")
  `ASSERT_CLK(a_take_idle, clk, rst_n, !(scan_take && out_valid),
              "scan taken while a result is pending")
  `ASSERT_CLK(a_floor_peak, clk, rst_n, !(out_valid && (pack_r > peak_r || pack_r < floor_r)),
              "pack outside its extremes")

endmodule

// ===== rtl/core/pack_cell_voltage_conditioner_unit.sv =====
// Pack cell voltage conditioner.
// Input channel (in_valid/in_stall/in_data): one transfer per module report of
// a pack scan; an item with last_of_scan set closes the scan. Bare items with
// present low carry only the marker. Each accepted report updates the scan
// extremes, sums and the all-time temperature extremes in the front part.
// A closing item hands a scan summary to a two-entry queue; the back part
// slew-limits the low/high cell values, runs a 17-step divide for the mean
// cell voltage into an 8-point moving average and a 20-step divide for the
// pack voltage, then presents one result on out_valid/out_data.
// From the closing transfer the summary passes the queue and the back states
// IDLE, SLEW, DIV (skipped for a scan with no report), RING, PACK and OUT; both
// divides share one divider; only IDLE takes a summary. Reports inside a scan
// go in one per cycle; a closing item stalls only when the queue is full.
// Reset (rst_n, synchronous) clears front scan, smoothing, ring and extreme
// state; step_mv and strings return to 1.
// While out_stall is high the result holds; the queue and front keep taking
// transfers until the queue fills. Write cfg_* only while the block is idle.
module pack_cell_voltage_conditioner_unit #(
  parameter int MAX_MODULES = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  pcvc_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output pcvc_pkg::out_item_t out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic                cfg_index,
  input  logic [9:0]          cfg_data
);

  logic [9:0] step_r;
  logic [4:0] strings_r;
  logic q_wv, q_wr, q_rv, q_take;
  pcvc_pkg::scan_t q_wd, q_rd;

  assign cfg_ready = 1'b1;

  // Hold configuration; write on each completed transfer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r    <= 10'd1;
      strings_r <= 5'd1;
    end else if (cfg_valid) begin
      if (cfg_index == 1'(pcvc_pkg::CFG_STEP_MV)) step_r <= cfg_data;
      else strings_r <= cfg_data[4:0];
    end
  end

  pcvc_front #(.MAX_MODULES(MAX_MODULES)) u_front (
    .clk, .rst_n, .in_valid, .in_stall, .in_data,
    .scan_valid(q_wv), .scan_ready(q_wr), .scan_data(q_wd)
  );

  pcvc_queue u_queue (
    .clk, .rst_n, .wr_valid(q_wv), .wr_ready(q_wr), .wr_data(q_wd),
    .rd_valid(q_rv), .rd_take(q_take), .rd_data(q_rd)
  );

  pcvc_back u_back (
    .clk, .rst_n, .step_mv(step_r), .strings(strings_r),
    .scan_valid(q_rv), .scan_take(q_take), .scan_data(q_rd),
    .out_valid, .out_stall, .out_data
  );

endmodule
